### src/rpa_pkg.sv
package rpa_pkg;

	// Field widths of the request and result items
	localparam int ADDR_W     = 40;
	localparam int PCNT_W     = 11;
	localparam int RCNT_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 40;

	// Pool geometry
	localparam int PAGES       = 1024;
	localparam int PAGE_SHIFT  = 12;
	localparam int COUNT_WIDTH = 16;
	localparam int IDX_W       = $clog2(PAGES);
	localparam int PAGES_W     = $clog2(PAGES + 1);
	localparam int PFN_W       = ADDR_W - PAGE_SHIFT;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [ADDR_W-1:0] REGION_BASE_RST = 40'h00_8000_0000;

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [PAGES_W-1:0]     pcnt_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		REQ_ALLOC,
		REQ_RELEASE,
		REQ_ADD_REF,
		REQ_READ
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_OOM,
		ST_BAD_ADDR,
		ST_STACK_FULL
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REGION_BASE,
		CFG_PAGE_COUNT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		req_type_t          req_type;
		logic [ADDR_W-1:0]  page_address;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [ADDR_W-1:0]  granted_address;
		logic [RCNT_W-1:0]  ref_count;
		logic               page_freed;
	} rsp_t;

	// Classified request handed from front to back
	typedef struct packed {
		req_type_t  req_type;
		logic       bad;
		idx_t       idx;
	} cmd_t;

	// Configuration seen by the back end
	typedef struct packed {
		logic [ADDR_W-1:0]  region_base;
		pcnt_t              page_count;
		logic               reinit;
		pcnt_t              init_pages;
	} cfg_t;

endpackage

### src/rpa_ram.sv
module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/rpa_cmdq.sv
module rpa_cmdq
	import rpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t din,
	output logic q_full,
	input  logic rd,
	output cmd_t dout,
	output logic q_empty
);

	cmd_t                  entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign dout    = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/rpa_front.sv
module rpa_front
	import rpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request side
	input  logic                  push,
	input  req_t                  req,
	output logic                  full,
	// towards the command queue
	input  logic                  cmd_full,
	input  logic                  busy,
	output logic                  cmd_push,
	output cmd_t                  cmd,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [ADDR_W-1:0] region_base_q;
	pcnt_t             page_count_q;
	logic [PCNT_W-1:0] pc_raw;
	pcnt_t             pc_sat;
	logic              wr_base;
	logic              wr_count;
	logic [ADDR_W:0]   diff;
	logic [PFN_W-1:0]  pfn;
	logic              aligned;
	logic              below;
	logic              in_range;

	// Register decode
	always_comb begin
		wr_base  = 1'b0;
		wr_count = 1'b0;
		unique case (cfg_reg_t'(cfg_index))
			CFG_REGION_BASE: wr_base  = cfg_we;
			CFG_PAGE_COUNT:  wr_count = cfg_we;
		endcase
	end

	// Page count saturates at the pool size
	assign pc_raw = cfg_data[PCNT_W-1:0];
	assign pc_sat = (32'(pc_raw) > PAGES) ? PAGES_W'(PAGES) : PAGES_W'(pc_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= REGION_BASE_RST;
			page_count_q  <= PAGES_W'(PAGES);
		end else begin
			if (wr_base) begin
				region_base_q <= {cfg_data[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
			end
			if (wr_count) begin
				page_count_q <= pc_sat;
			end
		end
	end

	assign cfg.region_base = region_base_q;
	assign cfg.page_count  = page_count_q;
	assign cfg.reinit      = wr_count;
	assign cfg.init_pages  = pc_sat;

	// Address check: aligned, not below the base, within the managed pages
	assign diff     = {1'b0, req.page_address} - {1'b0, region_base_q};
	assign below    = diff[ADDR_W];
	assign pfn      = diff[ADDR_W-1:PAGE_SHIFT];
	assign aligned  = (req.page_address[PAGE_SHIFT-1:0] == '0);
	assign in_range = (pfn < PFN_W'(page_count_q));

	always_comb begin
		cmd.req_type = req.req_type;
		cmd.idx      = pfn[IDX_W-1:0];
		cmd.bad      = (req.req_type != REQ_ALLOC) && (!aligned || below || !in_range);
	end

	assign full     = cmd_full || busy;
	assign cmd_push = push && !full;

endmodule

### src/rpa_back.sv
module rpa_back
	import rpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	// command queue
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic busy,
	// result side
	output logic empty,
	input  logic pop,
	output rsp_t rsp
);

	back_state_t state_q, state_d;
	cmd_t        cmd_s1;
	idx_t        clr_addr_q;
	pcnt_t       depth_q, depth_d;
	pcnt_t       untouched_q, untouched_d;
	pcnt_t       depth_dec;
	pcnt_t       ut_dec;
	rsp_t        rsp_q, rsp_d;
	logic        out_valid_q;
	logic        out_free;
	logic        done;

	// count memory ports
	logic   cnt_we, cnt_re;
	idx_t   cnt_waddr, cnt_raddr;
	count_t cnt_wdata, cnt_rdata;
	// free stack ports
	logic   stk_we, stk_re;
	idx_t   stk_waddr, stk_raddr;
	idx_t   stk_wdata, stk_rdata;

	rpa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(PAGES)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	rpa_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign depth_dec = depth_q - 1'b1;
	assign ut_dec    = untouched_q - 1'b1;
	assign out_free  = !out_valid_q || pop;
	assign busy      = (state_q == BK_CLEAR);
	assign empty     = !out_valid_q;
	assign rsp       = rsp_q;

	// Sequencer: clear sweep, read step, write step
	always_comb begin
		count_t c;
		idx_t   a_idx;
		c           = cnt_rdata;
		a_idx       = stk_rdata;
		state_d     = state_q;
		depth_d     = depth_q;
		untouched_d = untouched_q;
		cmd_pop     = 1'b0;
		done        = 1'b0;
		cnt_we      = 1'b0;
		cnt_waddr   = cmd_s1.idx;
		cnt_wdata   = '0;
		cnt_re      = 1'b0;
		cnt_raddr   = cmd.idx;
		stk_we      = 1'b0;
		stk_waddr   = depth_q[IDX_W-1:0];
		stk_wdata   = cmd_s1.idx;
		stk_re      = 1'b0;
		stk_raddr   = depth_dec[IDX_W-1:0];
		rsp_d       = '0;

		unique case (state_q)
			BK_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_addr_q;
				if (clr_addr_q == IDX_W'(PAGES - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					cnt_re  = 1'b1;
					stk_re  = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = BK_IDLE;
					if (cmd_s1.bad) begin
						rsp_d.status = ST_BAD_ADDR;
					end else begin
						case (cmd_s1.req_type)
							REQ_ALLOC: begin
								if (depth_q != '0) begin
									depth_d = depth_dec;
								end else if (untouched_q != '0) begin
									untouched_d = ut_dec;
									a_idx       = ut_dec[IDX_W-1:0];
								end
								if (depth_q != '0 || untouched_q != '0) begin
									cnt_we    = 1'b1;
									cnt_waddr = a_idx;
									cnt_wdata = COUNT_WIDTH'(1);
									rsp_d.ref_count       = RCNT_W'(1);
									rsp_d.granted_address = {
										cfg.region_base[ADDR_W-1:PAGE_SHIFT] + PFN_W'(a_idx),
										{PAGE_SHIFT{1'b0}}};
								end else begin
									rsp_d.status = ST_OOM;
								end
							end
							REQ_RELEASE: begin
								if (c == COUNT_WIDTH'(1)) begin
									if (depth_q == PAGES_W'(PAGES)) begin
										rsp_d.status    = ST_STACK_FULL;
										rsp_d.ref_count = RCNT_W'(c);
									end else begin
										cnt_we           = 1'b1;
										stk_we           = 1'b1;
										depth_d          = depth_q + 1'b1;
										rsp_d.page_freed = 1'b1;
									end
								end else if (c != '0) begin
									cnt_we          = 1'b1;
									cnt_wdata       = c - 1'b1;
									rsp_d.ref_count = RCNT_W'(c - 1'b1);
								end
							end
							REQ_ADD_REF: begin
								cnt_we          = 1'b1;
								cnt_wdata       = (c == '1) ? c : c + 1'b1;
								rsp_d.ref_count = RCNT_W'(cnt_wdata);
							end
							default: begin
								rsp_d.ref_count = RCNT_W'(c);
							end
						endcase
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			depth_q     <= '0;
			untouched_q <= PAGES_W'(PAGES);
		end else if (cfg.reinit) begin
			// pool restart: empty stack, every page untouched, counts swept
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			depth_q     <= '0;
			untouched_q <= cfg.init_pages;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			untouched_q <= untouched_d;
			if (state_q == BK_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Command held for the write step, and the result captured on completion
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
		if (done) begin
			rsp_q <= rsp_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= PAGES_W'(PAGES))
		else $error("free stack depth beyond pool size");

	a_untouched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		untouched_q <= cfg.page_count)
		else $error("untouched pages exceed page count");

	a_push_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (cmd_s1.req_type == REQ_RELEASE) && !cmd_s1.bad && done)
		else $error("free stack written outside a release");

	a_freed_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp_d.page_freed |-> rsp_d.status == ST_OK && rsp_d.ref_count == '0)
		else $error("freed page reported with non-zero count or bad status");

	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_CLEAR |=> !done)
		else $error("request completed right after clear sweep cycle");
`endif

endmodule

### src/refcounted_page_allocator_core.sv
// Channel   Handshake        Payload           Transfer when
// -------   --------------   ---------------   ---------------------
// request   push / full      req (req_t)       push && !full
// result    empty / pop      rsp (rsp_t)       pop && !empty
// config    cfg_we           cfg_index, data   cfg_we
//
// Each request passes through the back end as a count/stack memory read,
// then the count write and stack push, kept apart by the single read/write
// port pair of the count memory; the next request is read only once the
// last is written. After reset and every page_count write, a clearing pass
// over all 1024 entries zeroes the count memory; full stays high during it.
// A two-deep command queue parts front and back, and a held result stalls
// only the write step of the next request.
module refcounted_page_allocator_core
	import rpa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  req_t                  req,
	output logic                  empty,
	input  logic                  pop,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_pop, cmd_full, cmd_empty, busy;

	rpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.req       (req),
		.full      (full),
		.cmd_full  (cmd_full),
		.busy      (busy),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rpa_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_push),
		.din     (cmd_in),
		.q_full  (cmd_full),
		.rd      (cmd_pop),
		.dout    (cmd_out),
		.q_empty (cmd_empty)
	);

	rpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.busy      (busy),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule

### bench/tb_refcounted_page_allocator_core.sv
`timescale 1ns / 1ps

module tb_refcounted_page_allocator_core;
	import rpa_pkg::*;

	localparam logic [ADDR_W-1:0] IN_PAGE = (ADDR_W'(1) << PAGE_SHIFT) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	req_t                  req = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the allocator state
	count_t            page_refs [PAGES];
	idx_t              free_pages [PAGES];
	int                free_top;
	int                fresh_pages;
	int                pool_pages;
	logic [ADDR_W-1:0] pool_base;

	rsp_t              owed_rsp [$];
	logic [ADDR_W-1:0] live [$];      // recently granted pages, to aim requests at
	rsp_t              head;
	int                mismatches = 0;
	bit                quiet = 1'b0;  // no idling on either side while set

	refcounted_page_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [ADDR_W-1:0] page_addr(int i);
		return pool_base + (ADDR_W'(i) << PAGE_SHIFT);
	endfunction

	// Fresh pool: empty stack, every page untouched, all counts zero
	function automatic void reinit_pool(logic [PCNT_W-1:0] n);
		pool_pages  = (n > PAGES) ? PAGES : int'(n);
		free_top    = 0;
		fresh_pages = pool_pages;
		foreach (page_refs[i])
			page_refs[i] = '0;
		live.delete();
	endfunction

	// Expected result of one request, updating the shadow state
	function automatic rsp_t serve_request(req_t r);
		rsp_t              o;
		logic [ADDR_W-1:0] off;
		int                idx;
		bit                ok;
		o = '0;
		if (r.req_type == REQ_ALLOC) begin
			idx = -1;
			if (free_top > 0) begin
				free_top--;
				idx = int'(free_pages[free_top]);
			end else if (fresh_pages > 0) begin
				fresh_pages--;
				idx = fresh_pages;
			end
			if (idx >= 0) begin
				page_refs[idx]    = COUNT_WIDTH'(1);
				o.ref_count       = RCNT_W'(1);
				o.granted_address = page_addr(idx);
			end else begin
				o.status = ST_OOM;
			end
			return o;
		end
		off = r.page_address - pool_base;
		ok  = (r.page_address & IN_PAGE) == '0 && r.page_address >= pool_base &&
			(off >> PAGE_SHIFT) < ADDR_W'(pool_pages);
		if (!ok) begin
			o.status = ST_BAD_ADDR;
			return o;
		end
		idx = int'(off >> PAGE_SHIFT);
		case (r.req_type)
			REQ_RELEASE: begin
				if (page_refs[idx] == COUNT_WIDTH'(1)) begin
					if (free_top >= PAGES) begin
						o.status    = ST_STACK_FULL;
						o.ref_count = RCNT_W'(1);
					end else begin
						page_refs[idx]       = '0;
						free_pages[free_top] = idx_t'(idx);
						free_top++;
						o.page_freed = 1'b1;
					end
				end else if (page_refs[idx] > COUNT_WIDTH'(1)) begin
					page_refs[idx]--;
					o.ref_count = page_refs[idx];
				end
			end
			REQ_ADD_REF: begin
				if (page_refs[idx] != '1)
					page_refs[idx]++;
				o.ref_count = page_refs[idx];
			end
			default: o.ref_count = page_refs[idx];
		endcase
		return o;
	endfunction

	task automatic report_miss(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
	endtask

	// Send one request and log what it should return once transferred
	task automatic issue(req_type_t kind, logic [ADDR_W-1:0] addr);
		req_t r;
		rsp_t want;
		r.req_type     = kind;
		r.page_address = addr;
		if (!quiet && $urandom_range(99) < 6) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
		want = serve_request(r);
		owed_rsp.push_back(want);
		if (kind == REQ_ALLOC && want.status == ST_OK) begin
			live.push_back(want.granted_address);
			if (live.size() > 32)
				void'(live.pop_front());
		end
	endtask

	// Register write, only once the block has gone quiet
	task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
		push <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (which == CFG_REGION_BASE)
			pool_base = value[ADDR_W-1:0] & ~IN_PAGE;
		else
			reinit_pool(value[PCNT_W-1:0]);
	endtask

	// Random target address for a request, mostly aimed at real pages
	function automatic logic [ADDR_W-1:0] random_target();
		int                roll;
		logic [ADDR_W-1:0] any;
		roll = $urandom_range(99);
		any  = ADDR_W'({$urandom, $urandom});
		if (pool_pages == 0 || roll >= 94)
			return any;
		if (roll < 45 && live.size() != 0)
			return live[$urandom_range(live.size() - 1)];
		if (roll < 75)
			return page_addr($urandom_range(pool_pages - 1));
		if (roll < 82)
			return page_addr($urandom_range(pool_pages - 1)) |
				ADDR_W'($urandom_range(1, 32'(IN_PAGE)));
		if (roll < 88)
			return (pool_base == '0) ? any : any % pool_base;
		return page_addr(pool_pages + $urandom_range(3000));
	endfunction

	// One random request of any kind
	task automatic random_request();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			issue(REQ_ALLOC, ADDR_W'({$urandom, $urandom}));
		else if (roll < 60)
			issue(REQ_RELEASE, random_target());
		else if (roll < 80)
			issue(REQ_ADD_REF, random_target());
		else
			issue(REQ_READ, random_target());
	endtask

	// Result side: random stalls on pop, each transfer checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (owed_rsp.size() == 0) begin
					report_miss("unexpected result", '0, 64'(rsp));
				end else begin
					head = owed_rsp.pop_front();
					if (rsp.status !== head.status)
						report_miss("status", 64'(head.status), 64'(rsp.status));
					if (rsp.granted_address !== head.granted_address)
						report_miss("granted_address", 64'(head.granted_address),
							64'(rsp.granted_address));
					if (rsp.ref_count !== head.ref_count)
						report_miss("ref_count", 64'(head.ref_count), 64'(rsp.ref_count));
					if (rsp.page_freed !== head.page_freed)
						report_miss("page_freed", 64'(head.page_freed), 64'(rsp.page_freed));
				end
			end
			pop <= quiet || ($urandom_range(99) >= 6);
		end
	end

	// Every operation and the corner cases, first on the reset configuration, then on reconfigured pools
	task automatic test_directed();
		issue(REQ_ALLOC, '0);
		issue(REQ_ALLOC, '1);
		issue(REQ_READ, page_addr(1023));
		issue(REQ_ADD_REF, page_addr(1023));
		issue(REQ_ADD_REF, page_addr(1023));
		repeat (3) issue(REQ_RELEASE, page_addr(1023));
		// count already zero: nothing pushed
		issue(REQ_RELEASE, page_addr(1023));
		issue(REQ_ALLOC, '0);
		issue(REQ_READ, page_addr(0));
		issue(REQ_READ, page_addr(1023) | 40'h800);
		issue(REQ_ADD_REF, pool_base - 40'h1000);
		issue(REQ_RELEASE, page_addr(1024));
		issue(REQ_READ, '1);
		issue(REQ_READ, '0);
		// empty pool
		write_reg(CFG_PAGE_COUNT, '0);
		issue(REQ_ALLOC, '0);
		issue(REQ_READ, pool_base);
		// single page, then out of memory
		write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(1));
		issue(REQ_ALLOC, '0);
		issue(REQ_ALLOC, '0);
		// top of the address space, count saturated to the pool size: grant wraps
		write_reg(CFG_REGION_BASE, '1);
		write_reg(CFG_PAGE_COUNT, 40'hFF_FFFF_F7FF);
		issue(REQ_ALLOC, '0);
		issue(REQ_READ, pool_base);
		write_reg(CFG_REGION_BASE, '0);
		write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(PAGES));
		issue(REQ_ADD_REF, '0);
		issue(REQ_READ, page_addr(0));
	endtask

	// Back-to-back traffic on a small pool, with no idling on either side
	task automatic test_no_idle();
		quiet = 1'b1;
		write_reg(CFG_REGION_BASE, CFG_DATA_W'({$urandom, $urandom}));
		write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(24));
		repeat (150) random_request();
		quiet = 1'b0;
	endtask

	// Phases of random traffic over a spread of pool sizes and bases
	task automatic test_random_traffic();
		logic [ADDR_W-1:0] base;
		logic [CFG_DATA_W-1:0] count_word;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(3))
				0:       base = '0;
				1:       base = '1;
				default: base = ADDR_W'({$urandom, $urandom});
			endcase
			write_reg(CFG_REGION_BASE, base);
			count_word = CFG_DATA_W'({$urandom, $urandom});
			case (ph % 4)
				0:       count_word[PCNT_W-1:0] = PCNT_W'($urandom_range(1, 8));
				1:       count_word[PCNT_W-1:0] = PCNT_W'($urandom_range(9, 200));
				2:       count_word[PCNT_W-1:0] = PCNT_W'($urandom_range(201, PAGES));
				default: count_word[PCNT_W-1:0] = PCNT_W'($urandom_range(PAGES + 1, 2047));
			endcase
			write_reg(CFG_PAGE_COUNT, count_word);
			repeat (150) random_request();
		end
	endtask

	initial begin
		int guard;
		pool_base = REGION_BASE_RST;
		reinit_pool(PCNT_W'(PAGES));
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_no_idle();
		test_random_traffic();

		// drain what is still owed, then give stray results a chance to show
		push <= 1'b0;
		guard = 0;
		while (owed_rsp.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (owed_rsp.size() == 0 && mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest legitimate run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

### sim.f
src/rpa_pkg.sv
src/rpa_ram.sv
src/rpa_cmdq.sv
src/rpa_front.sv
src/rpa_back.sv
src/refcounted_page_allocator_core.sv
bench/tb_refcounted_page_allocator_core.sv
